>>> sv/aibd_pkg.sv
// Shared constants, codes and types of the audio intensity and beat detector.
`default_nettype none

package aibd_pkg;

  // ring of mono magnitudes
  localparam int WINDOW_SAMPLES = 512;
  localparam int POS_W          = $clog2(WINDOW_SAMPLES);
  localparam int SMP_W          = 16;
  localparam int MAG_W          = 16;
  localparam int SUM_W          = MAG_W + $clog2(WINDOW_SAMPLES);

  // energy history
  localparam int HISTORY_DEPTH  = 5;
  localparam int HIST_IDX_W     = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

  // field widths
  localparam int ET_W      = 9;
  localparam int SENS_W    = 7;
  localparam int E_W       = 16;
  localparam int V_W       = 17;
  localparam int T_W       = 9;
  localparam int LIM_W     = 12;
  localparam int ACC_W     = 17;
  localparam int INT_W     = 16;
  localparam int WB_W      = 17;
  localparam int SCALE_W   = 13;
  localparam int PROD_W    = ACC_W + SCALE_W;
  localparam int CFG_IDX_W = 2;
  localparam int N_W       = 2;

  // arithmetic constants
  localparam int T_CAP       = 256;
  localparam int T_HALF      = 128;
  localparam int SENS_MAX    = 100;
  localparam int LIM_BASE    = 2500;
  localparam int LIM_STEP    = 24;
  localparam int BEAT_SH     = 15;      // 163840 = 5 << 15
  localparam int ACC_CAP     = 65536;
  localparam int BEAT_MAX    = 39322;
  localparam int WB_MAX      = 131071;
  localparam int DEN_K       = 12288;
  localparam int DEC_M       = 209716;  // ceil(2^20 / 5), exact below 2^18
  localparam int DEC_SH      = 20;
  localparam int SCALE_FRAC  = 12;
  localparam int MAX_RESULTS = 2;

  // shared shift-subtract divider
  localparam int DIVS_W    = SUM_W + 4;
  localparam int DIVD_W    = DIVS_W + INT_W;
  localparam int DIV_CNT_W = $clog2(DIVD_W + 1);

  // codes
  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_UPDATE = 1'b1;
  localparam logic [CFG_IDX_W-1:0] CFG_AVOID = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE = 2'd1;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [DIVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DIVD_W-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic               avoid;
    logic [SCALE_W-1:0] scale;
  } cfg_t;

  typedef struct packed {
    logic [ET_W-1:0]   elapsed_time;
    logic [SENS_W-1:0] sensitivity;
    logic [E_W-1:0]    low_band_energy;
  } upd_t;

  typedef struct packed {
    logic [INT_W-1:0] intensity;
    logic [INT_W-1:0] beat_level;
    logic             beat_flag;
    logic [WB_W-1:0]  intensity_with_beat;
    logic             last_result;
  } res_t;

endpackage

`default_nettype wire

>>> sv/aibd_in_if.sv
// Input item channel: audio samples and analysis updates.
`default_nettype none

interface aibd_in_if;
  logic                              valid;
  logic                              ready;
  logic                              action;
  logic signed [aibd_pkg::SMP_W-1:0] left_sample;
  logic signed [aibd_pkg::SMP_W-1:0] right_sample;
  logic [aibd_pkg::ET_W-1:0]         elapsed_time;
  logic [aibd_pkg::SENS_W-1:0]       sensitivity;
  logic [aibd_pkg::E_W-1:0]          low_band_energy;

  modport source (
    output valid, action, left_sample, right_sample, elapsed_time, sensitivity,
           low_band_energy,
    input  ready
  );
  modport sink (
    input  valid, action, left_sample, right_sample, elapsed_time, sensitivity,
           low_band_energy,
    output ready
  );
endinterface

`default_nettype wire

>>> sv/aibd_out_if.sv
// Result item channel: one item per analysis period.
`default_nettype none

interface aibd_out_if;
  logic                         valid;
  logic                         ready;
  logic [aibd_pkg::INT_W-1:0]   intensity;
  logic [aibd_pkg::INT_W-1:0]   beat_level;
  logic                         beat_flag;
  logic [aibd_pkg::WB_W-1:0]    intensity_with_beat;
  logic                         last_result;

  modport source (
    output valid, intensity, beat_level, beat_flag, intensity_with_beat, last_result,
    input  ready
  );
  modport sink (
    input  valid, intensity, beat_level, beat_flag, intensity_with_beat, last_result,
    output ready
  );
endinterface

`default_nettype wire

>>> sv/aibd_cfg_if.sv
// Configuration write channel: register index and write data.
`default_nettype none

interface aibd_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [aibd_pkg::CFG_IDX_W-1:0] index;
  logic [aibd_pkg::SCALE_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> sv/audio_intensity_beat_detector.sv
// Top level of the audio intensity and beat detector.
`default_nettype none

// Sample items (action 0) are taken one per cycle while no update is analysed
// and need no result; the mono magnitude goes through a 512-entry ring memory
// with a two-stage read and write-back, and entries that have not been written
// since reset read as zero, so no clearing pass is needed after reset. An
// update item (action 1) holds the input for the length of its analysis: the
// period check alone when no period runs; otherwise, for each of one or two
// periods, the intensity division, outside avoid mode the history scan and on
// a beat the beat-gain division, plus any wait for the output register to
// free. The shared shift-subtract divider takes one quotient bit a cycle over
// a 45-bit dividend, once for intensity and once more for the beat gain when
// a beat is found. Configuration writes are taken in every cycle.
module audio_intensity_beat_detector (
  input wire logic   clk,
  input wire logic   rst_n,
  aibd_in_if.sink    in_ch,
  aibd_out_if.source out_ch,
  aibd_cfg_if.sink   cfg_ch
);

  logic                         avoid_r;
  logic [aibd_pkg::SCALE_W-1:0] scale_r;
  logic                         in_acc;
  logic                         smp_valid;
  logic                         upd_valid;
  logic                         ctrl_idle;
  logic [aibd_pkg::SUM_W-1:0]   mag_sum;
  aibd_pkg::cfg_t               cfg;
  aibd_pkg::upd_t               upd;
  aibd_pkg::div_req_t           div_req;
  aibd_pkg::div_rsp_t           div_rsp;
  aibd_pkg::res_t               res;
  logic                         res_valid;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avoid_r <= 1'b0;
      scale_r <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        aibd_pkg::CFG_AVOID: avoid_r <= cfg_ch.data[0];
        aibd_pkg::CFG_SCALE: scale_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  assign cfg.avoid = avoid_r;
  assign cfg.scale = scale_r;

  assign in_ch.ready = ctrl_idle;
  assign in_acc      = in_ch.valid && ctrl_idle;
  assign smp_valid   = in_acc && (in_ch.action == aibd_pkg::ACT_SAMPLE);
  assign upd_valid   = in_acc && (in_ch.action == aibd_pkg::ACT_UPDATE);

  assign upd.elapsed_time    = in_ch.elapsed_time;
  assign upd.sensitivity     = in_ch.sensitivity;
  assign upd.low_band_energy = in_ch.low_band_energy;

  aibd_ring u_ring (
    .clk          (clk),
    .rst_n        (rst_n),
    .smp_valid    (smp_valid),
    .left_sample  (in_ch.left_sample),
    .right_sample (in_ch.right_sample),
    .sum          (mag_sum)
  );

  aibd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  aibd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .upd_valid (upd_valid),
    .upd       (upd),
    .sum       (mag_sum),
    .cfg       (cfg),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .out_ready (out_ch.ready),
    .idle      (ctrl_idle),
    .out_valid (res_valid),
    .out_res   (res)
  );

  assign out_ch.valid               = res_valid;
  assign out_ch.intensity           = res.intensity;
  assign out_ch.beat_level          = res.beat_level;
  assign out_ch.beat_flag           = res.beat_flag;
  assign out_ch.intensity_with_beat = res.intensity_with_beat;
  assign out_ch.last_result         = res.last_result;

endmodule

`default_nettype wire

>>> sv/aibd_ring.sv
// Magnitude ring memory with running sum, one sample item per cycle.
`default_nettype none

module aibd_ring (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              smp_valid,
  input  wire logic signed [aibd_pkg::SMP_W-1:0] left_sample,
  input  wire logic signed [aibd_pkg::SMP_W-1:0] right_sample,
  output logic [aibd_pkg::SUM_W-1:0]             sum
);

  logic [aibd_pkg::MAG_W-1:0] mem [aibd_pkg::WINDOW_SAMPLES];

  logic [aibd_pkg::POS_W-1:0] pos_r;
  logic                       wrap_r;
  logic                       s2_valid_r;
  logic                       s2_old_ok_r;
  logic [aibd_pkg::POS_W-1:0] s2_pos_r;
  logic [aibd_pkg::MAG_W-1:0] s2_mag_r;
  logic [aibd_pkg::MAG_W-1:0] rd_data_r;
  logic [aibd_pkg::SUM_W-1:0] sum_r;
  logic [aibd_pkg::SUM_W-1:0] sum_nxt;

  logic signed [aibd_pkg::SMP_W:0] pair;
  logic signed [aibd_pkg::SMP_W:0] pair_adj;
  logic signed [aibd_pkg::SMP_W:0] mono;
  logic [aibd_pkg::SMP_W:0]        mono_abs;
  logic [aibd_pkg::MAG_W-1:0]      mag;
  logic [aibd_pkg::MAG_W-1:0]      old_mag;
  logic [aibd_pkg::POS_W-1:0]      pos_nxt;
  logic                            last_pos;

  // mono = (l + r) / 2 truncated toward zero
  assign pair     = (aibd_pkg::SMP_W+1)'(left_sample) + (aibd_pkg::SMP_W+1)'(right_sample);
  assign pair_adj = pair + $signed({{aibd_pkg::SMP_W{1'b0}}, pair[aibd_pkg::SMP_W]});
  assign mono     = pair_adj >>> 1;
  assign mono_abs = mono[aibd_pkg::SMP_W] ? $unsigned(-mono) : $unsigned(mono);
  assign mag      = mono_abs[aibd_pkg::MAG_W-1:0];

  assign last_pos = (pos_r == aibd_pkg::POS_W'(aibd_pkg::WINDOW_SAMPLES - 1));
  assign pos_nxt  = last_pos ? '0 : pos_r + 1'b1;

  // entries not yet written in the first lap read as zero
  assign old_mag = s2_old_ok_r ? rd_data_r : '0;
  assign sum_nxt = sum_r - aibd_pkg::SUM_W'(old_mag) + aibd_pkg::SUM_W'(s2_mag_r);
  assign sum     = sum_r;

  always_ff @(posedge clk) begin
    if (s2_valid_r) begin
      mem[s2_pos_r] <= s2_mag_r;
    end
    if (smp_valid) begin
      rd_data_r <= mem[pos_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      wrap_r     <= 1'b0;
      s2_valid_r <= 1'b0;
      sum_r      <= '0;
    end else begin
      s2_valid_r <= smp_valid;
      if (smp_valid) begin
        pos_r <= pos_nxt;
        if (last_pos) begin
          wrap_r <= 1'b1;
        end
      end
      if (s2_valid_r) begin
        sum_r <= sum_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (smp_valid) begin
      s2_pos_r    <= pos_r;
      s2_mag_r    <= mag;
      s2_old_ok_r <= wrap_r;
    end
  end

  // a read never hits the entry being written back
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r && smp_valid |-> s2_pos_r != pos_r)
    else $error("ring read and write-back hit the same entry");

endmodule

`default_nettype wire

>>> sv/aibd_div.sv
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none

module aibd_div (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire aibd_pkg::div_req_t req,
  output aibd_pkg::div_rsp_t      rsp
);

  logic                           busy_r;
  logic                           done_r;
  logic [aibd_pkg::DIV_CNT_W-1:0] cnt_r;
  logic [aibd_pkg::DIVS_W-1:0]    rem_r;
  logic [aibd_pkg::DIVD_W-1:0]    q_r;
  logic [aibd_pkg::DIVS_W-1:0]    d_r;

  logic [aibd_pkg::DIVS_W:0] rem_sh;
  logic [aibd_pkg::DIVS_W:0] rem_sub;
  logic                      ge;

  assign rem_sh  = {rem_r, q_r[aibd_pkg::DIVD_W-1]};
  assign ge      = rem_sh >= {1'b0, d_r};
  assign rem_sub = rem_sh - {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= aibd_pkg::DIV_CNT_W'(aibd_pkg::DIVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == aibd_pkg::DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // dividend shifts out of q_r as quotient bits shift in
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      q_r   <= req.dividend;
      d_r   <= req.divisor;
    end else if (busy_r) begin
      rem_r <= ge ? rem_sub[aibd_pkg::DIVS_W-1:0] : rem_sh[aibd_pkg::DIVS_W-1:0];
      q_r   <= {q_r[aibd_pkg::DIVD_W-2:0], ge};
    end
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = q_r;

endmodule

`default_nettype wire

>>> sv/aibd_ctrl.sv
// Analysis sequencer: time accumulation, intensity, beat detection and result register.
`default_nettype none

module aibd_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        upd_valid,
  input  wire aibd_pkg::upd_t              upd,
  input  wire logic [aibd_pkg::SUM_W-1:0]  sum,
  input  wire aibd_pkg::cfg_t              cfg,
  output aibd_pkg::div_req_t               div_req,
  input  wire aibd_pkg::div_rsp_t          div_rsp,
  input  wire logic                        out_ready,
  output logic                             idle,
  output logic                             out_valid,
  output aibd_pkg::res_t                   out_res
);

  localparam logic [3:0] ST_IDLE      = 4'd0;
  localparam logic [3:0] ST_CHECK     = 4'd1;
  localparam logic [3:0] ST_INT_WAIT  = 4'd2;
  localparam logic [3:0] ST_RISE      = 4'd3;
  localparam logic [3:0] ST_BEAT      = 4'd4;
  localparam logic [3:0] ST_BEAT_WAIT = 4'd5;
  localparam logic [3:0] ST_DECAY     = 4'd6;
  localparam logic [3:0] ST_SCALE     = 4'd7;
  localparam logic [3:0] ST_LOAD      = 4'd8;

  localparam int R5_W  = aibd_pkg::V_W + 3;
  localparam int S9_W  = aibd_pkg::SUM_W + 4;
  localparam int DEC_W = aibd_pkg::DEC_SH + aibd_pkg::ACC_W;

  logic [3:0]                  state_r, state_nxt;
  logic [aibd_pkg::T_W-1:0]    t_r, t_nxt;
  logic [aibd_pkg::N_W-1:0]    n_r, n_nxt;
  logic [aibd_pkg::V_W-1:0]    hist_r [aibd_pkg::HISTORY_DEPTH];
  logic [aibd_pkg::V_W-1:0]    hist_nxt [aibd_pkg::HISTORY_DEPTH];
  logic [aibd_pkg::ACC_W-1:0]  acc_r, acc_nxt;
  logic                        beat_r, beat_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [aibd_pkg::V_W-1:0]    v_r, v_nxt;
  logic [aibd_pkg::LIM_W-1:0]  lim_r, lim_nxt;
  logic [aibd_pkg::HIST_IDX_W-1:0] idx_r, idx_nxt;
  logic [aibd_pkg::V_W-1:0]    rise_r, rise_nxt;
  logic [aibd_pkg::INT_W-1:0]  inten_r, inten_nxt;
  logic [aibd_pkg::PROD_W-1:0] prod_r, prod_nxt;
  aibd_pkg::res_t              res_r, res_nxt;

  logic [aibd_pkg::SENS_W-1:0] sens_c;
  logic [aibd_pkg::LIM_W-1:0]  lim_c;
  logic [aibd_pkg::T_W:0]      t_sum;
  logic [aibd_pkg::T_W-1:0]    t_cap;
  logic [aibd_pkg::E_W+1:0]    e3;
  logic [aibd_pkg::V_W-1:0]    hist_sel;
  logic [aibd_pkg::V_W-1:0]    diff;
  logic                        rise_gt;
  logic [R5_W-1:0]             rise5;
  logic                        beat_hit;
  logic [S9_W-1:0]             s9;
  logic [S9_W-1:0]             den;
  logic [aibd_pkg::INT_W-1:0]  inten_q;
  logic [aibd_pkg::DIVD_W:0]   acc_add;
  logic [aibd_pkg::ACC_W:0]    dec_in;
  logic [DEC_W-1:0]            dec_prod;
  logic [aibd_pkg::WB_W+1:0]   wb_sum;
  logic [aibd_pkg::WB_W-1:0]   wb_sat;
  logic [aibd_pkg::T_W-1:0]    t_left;
  logic [aibd_pkg::N_W-1:0]    n_inc;
  logic                        more;
  logic                        load;

  // per-update operands
  assign sens_c = (upd.sensitivity > aibd_pkg::SENS_W'(aibd_pkg::SENS_MAX)) ?
                  aibd_pkg::SENS_W'(aibd_pkg::SENS_MAX) : upd.sensitivity;
  assign lim_c  = aibd_pkg::LIM_W'(aibd_pkg::LIM_BASE)
                - aibd_pkg::LIM_W'(sens_c) * aibd_pkg::LIM_W'(aibd_pkg::LIM_STEP);
  assign t_sum  = (aibd_pkg::T_W+1)'(t_r) + (aibd_pkg::T_W+1)'(upd.elapsed_time);
  assign t_cap  = (t_sum > (aibd_pkg::T_W+1)'(aibd_pkg::T_CAP)) ?
                  aibd_pkg::T_W'(aibd_pkg::T_CAP) : t_sum[aibd_pkg::T_W-1:0];
  assign e3     = (aibd_pkg::E_W+2)'(upd.low_band_energy)
                + (aibd_pkg::E_W+2)'({upd.low_band_energy, 1'b0});

  // history scan
  assign hist_sel = hist_r[idx_r];
  assign diff     = v_r - hist_sel;
  assign rise_gt  = (v_r > hist_sel) && (diff > rise_r);
  assign rise5    = R5_W'({rise_r, 2'b00}) + R5_W'(rise_r);
  assign beat_hit = rise5 > R5_W'(lim_r);

  // intensity = 65536 * 9S / (9S + 12288N)
  assign s9  = S9_W'(sum) + (S9_W'(sum) << 3);
  assign den = s9 + S9_W'(aibd_pkg::DEN_K * aibd_pkg::WINDOW_SAMPLES);
  assign inten_q = (|div_rsp.quotient[aibd_pkg::DIVD_W-1:aibd_pkg::INT_W]) ?
                   '1 : div_rsp.quotient[aibd_pkg::INT_W-1:0];

  assign acc_add  = (aibd_pkg::DIVD_W+1)'(acc_r) + (aibd_pkg::DIVD_W+1)'(div_rsp.quotient);
  // round(acc * 3 / 5) by reciprocal multiply
  assign dec_in   = (aibd_pkg::ACC_W+1)'({acc_r, 1'b0}) + (aibd_pkg::ACC_W+1)'(acc_r)
                  + (aibd_pkg::ACC_W+1)'(2);
  assign dec_prod = DEC_W'(dec_in) * DEC_W'(aibd_pkg::DEC_M);

  assign wb_sum = (aibd_pkg::WB_W+2)'(prod_r >> aibd_pkg::SCALE_FRAC)
                + (aibd_pkg::WB_W+2)'(inten_r);
  assign wb_sat = (wb_sum > (aibd_pkg::WB_W+2)'(aibd_pkg::WB_MAX)) ?
                  aibd_pkg::WB_W'(aibd_pkg::WB_MAX) : wb_sum[aibd_pkg::WB_W-1:0];

  assign t_left = t_r - aibd_pkg::T_W'(aibd_pkg::T_HALF);
  assign n_inc  = n_r + 1'b1;
  assign more   = (t_left > aibd_pkg::T_W'(aibd_pkg::T_HALF))
               && (n_inc < aibd_pkg::N_W'(aibd_pkg::MAX_RESULTS));
  assign load   = (state_r == ST_LOAD) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt     = state_r;
    t_nxt         = t_r;
    n_nxt         = n_r;
    hist_nxt      = hist_r;
    acc_nxt       = acc_r;
    beat_nxt      = beat_r;
    v_nxt         = v_r;
    lim_nxt       = lim_r;
    idx_nxt       = idx_r;
    rise_nxt      = rise_r;
    inten_nxt     = inten_r;
    prod_nxt      = prod_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;

    div_req.start    = 1'b0;
    div_req.dividend = {s9, {aibd_pkg::INT_W{1'b0}}};
    div_req.divisor  = den;

    case (state_r)
      ST_IDLE: begin
        if (upd_valid) begin
          t_nxt     = t_cap;
          n_nxt     = '0;
          v_nxt     = e3[aibd_pkg::E_W+1:1];
          lim_nxt   = lim_c;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if ((t_r > aibd_pkg::T_W'(aibd_pkg::T_HALF))
            && (n_r < aibd_pkg::N_W'(aibd_pkg::MAX_RESULTS))) begin
          div_req.start = 1'b1;
          state_nxt     = ST_INT_WAIT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_INT_WAIT: begin
        if (div_rsp.done) begin
          inten_nxt = inten_q;
          if (cfg.avoid) begin
            // flag and history hold
            acc_nxt   = '0;
            state_nxt = ST_SCALE;
          end else begin
            idx_nxt   = '0;
            rise_nxt  = '0;
            state_nxt = ST_RISE;
          end
        end
      end
      ST_RISE: begin
        if (rise_gt) begin
          rise_nxt = diff;
        end
        if (idx_r == aibd_pkg::HIST_IDX_W'(aibd_pkg::HISTORY_DEPTH - 1)) begin
          state_nxt = ST_BEAT;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_BEAT: begin
        for (int i = aibd_pkg::HISTORY_DEPTH - 1; i > 0; i--) begin
          hist_nxt[i] = hist_r[i-1];
        end
        hist_nxt[0] = v_r;
        if (beat_hit) begin
          beat_nxt         = 1'b1;
          div_req.start    = 1'b1;
          div_req.dividend = aibd_pkg::DIVD_W'(rise5) << aibd_pkg::BEAT_SH;
          div_req.divisor  = aibd_pkg::DIVS_W'(lim_r);
          state_nxt        = ST_BEAT_WAIT;
        end else begin
          beat_nxt  = 1'b0;
          state_nxt = ST_DECAY;
        end
      end
      ST_BEAT_WAIT: begin
        if (div_rsp.done) begin
          acc_nxt   = (acc_add > (aibd_pkg::DIVD_W+1)'(aibd_pkg::ACC_CAP)) ?
                      aibd_pkg::ACC_W'(aibd_pkg::ACC_CAP) : acc_add[aibd_pkg::ACC_W-1:0];
          state_nxt = ST_DECAY;
        end
      end
      ST_DECAY: begin
        acc_nxt   = dec_prod[DEC_W-1:aibd_pkg::DEC_SH];
        state_nxt = ST_SCALE;
      end
      ST_SCALE: begin
        prod_nxt  = aibd_pkg::PROD_W'(acc_r) * aibd_pkg::PROD_W'(cfg.scale);
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        // hold until the output register frees
        if (load) begin
          out_valid_nxt               = 1'b1;
          res_nxt.intensity           = inten_r;
          res_nxt.beat_level          = acc_r[aibd_pkg::INT_W-1:0];
          res_nxt.beat_flag           = beat_r;
          res_nxt.intensity_with_beat = wb_sat;
          res_nxt.last_result         = !more;
          t_nxt                       = t_left;
          n_nxt                       = n_inc;
          state_nxt                   = ST_CHECK;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      t_r         <= '0;
      n_r         <= '0;
      hist_r      <= '{default: '0};
      acc_r       <= '0;
      beat_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      t_r         <= t_nxt;
      n_r         <= n_nxt;
      hist_r      <= hist_nxt;
      acc_r       <= acc_nxt;
      beat_r      <= beat_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r     <= v_nxt;
    lim_r   <= lim_nxt;
    idx_r   <= idx_nxt;
    rise_r  <= rise_nxt;
    inten_r <= inten_nxt;
    prod_r  <= prod_nxt;
    res_r   <= res_nxt;
  end

  assign idle      = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_LOAD |-> acc_r <= aibd_pkg::ACC_W'(aibd_pkg::BEAT_MAX))
    else $error("beat level above decayed maximum");

  a_time_cap: assert property (@(posedge clk) disable iff (!rst_n)
    upd_valid |=> t_r <= aibd_pkg::T_W'(aibd_pkg::T_CAP) && state_r == ST_CHECK)
    else $error("time accumulator above one second after update");

endmodule

`default_nettype wire

>>> tb/sv/tb_audio_intensity_beat_detector.sv
// Self-checking testbench for the audio intensity and beat detector.

module tb_audio_intensity_beat_detector;
  import aibd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE0 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE1 = 2'd3;
  localparam int QUIET_CYCLES = 150;
  localparam int RUN_LIMIT = 40000000;

  // Tracks the detector state and the analysis periods still to come out.
  class period_board;
    logic [MAG_W-1:0] mag_ring [WINDOW_SAMPLES];
    int unsigned      ring_pos;
    longint unsigned  mag_total;
    longint unsigned  energy_hist [HISTORY_DEPTH];
    longint unsigned  beat_acc;
    bit               beat_seen;
    int unsigned      time_acc;
    bit               avoid_mode;
    longint unsigned  beat_scale;
    res_t             periods_due [$];
    res_t             periods_seen [$];
    bit               update_offered;
    int unsigned      faults;

    function new();
      foreach (mag_ring[i]) mag_ring[i] = '0;
      foreach (energy_hist[i]) energy_hist[i] = 0;
      ring_pos = 0;
      mag_total = 0;
      beat_acc = 0;
      beat_seen = 1'b0;
      time_acc = 0;
      avoid_mode = 1'b0;
      beat_scale = 0;
      update_offered = 1'b0;
      faults = 0;
    endfunction

    function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SCALE_W-1:0] word);
      if (idx == CFG_AVOID) begin
        avoid_mode = word[0];
      end else if (idx == CFG_SCALE) begin
        beat_scale = word;
      end
    endfunction

    function res_t analyze_period(input longint unsigned sens, input longint unsigned energy);
      longint unsigned s9, inten, v, rise, lim5, acc, withb;
      res_t r;
      int i;
      s9 = 9 * mag_total;
      inten = (s9 * 65536) / (s9 + 64'd12288 * WINDOW_SAMPLES);
      if (inten > 65535) inten = 65535;
      if (avoid_mode) begin
        beat_acc = 0;
      end else begin
        v = (3 * energy) / 2;
        rise = 0;
        lim5 = 2500 - 24 * sens;
        acc = beat_acc;
        for (i = 0; i < HISTORY_DEPTH; i++) begin
          if (v > energy_hist[i] && v - energy_hist[i] > rise) rise = v - energy_hist[i];
        end
        if (5 * rise > lim5) begin
          beat_seen = 1'b1;
          acc += (163840 * rise) / lim5;
          if (acc > 65536) acc = 65536;
        end else begin
          beat_seen = 1'b0;
        end
        for (i = HISTORY_DEPTH - 1; i > 0; i--) energy_hist[i] = energy_hist[i-1];
        energy_hist[0] = v;
        // decay by 0.6 with rounding
        beat_acc = (acc * 3 + 2) / 5;
      end
      withb = inten + (beat_acc * beat_scale) / 4096;
      if (withb > 131071) withb = 131071;
      r.intensity = inten[INT_W-1:0];
      r.beat_level = beat_acc[INT_W-1:0];
      r.beat_flag = beat_seen;
      r.intensity_with_beat = withb[WB_W-1:0];
      r.last_result = 1'b0;
      return r;
    endfunction

    function void note_item(input logic act, input logic signed [SMP_W-1:0] l,
                            input logic signed [SMP_W-1:0] rs, input logic [ET_W-1:0] et,
                            input logic [SENS_W-1:0] sens, input logic [E_W-1:0] energy);
      int total, mono;
      int unsigned mag, n;
      longint unsigned s;
      res_t r;
      update_offered = 1'b0;
      if (act == ACT_SAMPLE) begin
        total = l;
        total = total + rs;
        mono = total / 2;
        mag = (mono < 0) ? -mono : mono;
        mag_total = mag_total - mag_ring[ring_pos] + mag;
        mag_ring[ring_pos] = mag[MAG_W-1:0];
        ring_pos = (ring_pos + 1) % WINDOW_SAMPLES;
      end else begin
        s = (sens > 100) ? 100 : sens;
        time_acc += et;
        if (time_acc > 256) time_acc = 256;
        n = 0;
        while (time_acc > 128 && n < MAX_RESULTS) begin
          r = analyze_period(s, energy);
          time_acc -= 128;
          n++;
          r.last_result = !(time_acc > 128 && n < MAX_RESULTS);
          periods_due.push_back(r);
        end
      end
    endfunction

    function void compare_field(input string what, input longint unsigned want,
                                input longint unsigned got);
      if (want != got) begin
        $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
        faults++;
      end
    endfunction

    function void check_period(input res_t got);
      res_t want, seen;
      periods_seen.push_back(got);
      while (periods_seen.size() > 0) begin
        if (periods_due.size() == 0) begin
          // an update still on offer may account for this item
          if (update_offered) break;
          seen = periods_seen.pop_front();
          $display("%0t: unexpected result, expected none, got intensity %0d beat_level %0d",
                   $time, seen.intensity, seen.beat_level);
          faults++;
        end else begin
          want = periods_due.pop_front();
          seen = periods_seen.pop_front();
          compare_field("intensity", want.intensity, seen.intensity);
          compare_field("beat_level", want.beat_level, seen.beat_level);
          compare_field("beat_flag", want.beat_flag, seen.beat_flag);
          compare_field("intensity_with_beat", want.intensity_with_beat,
                        seen.intensity_with_beat);
          compare_field("last_result", want.last_result, seen.last_result);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   calm;
  period_board sb = new();

  aibd_in_if  in_ch ();
  aibd_out_if out_ch ();
  aibd_cfg_if cfg_ch ();

  audio_intensity_beat_detector uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #RUN_LIMIT;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // result side: sample at the edge, check a moment later so same-edge input
  // acceptance is already noted
  initial begin
    res_t got;
    bit   took;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      took = out_ch.valid && out_ch.ready;
      got.intensity = out_ch.intensity;
      got.beat_level = out_ch.beat_level;
      got.beat_flag = out_ch.beat_flag;
      got.intensity_with_beat = out_ch.intensity_with_beat;
      got.last_result = out_ch.last_result;
      out_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 19);
      if (took) begin
        #1;
        sb.check_period(got);
      end
    end
  end

  task automatic send_item(input logic act, input logic signed [SMP_W-1:0] l,
                           input logic signed [SMP_W-1:0] rs, input logic [ET_W-1:0] et,
                           input logic [SENS_W-1:0] sens, input logic [E_W-1:0] energy);
    while (!calm && $urandom_range(99) < 19) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= act;
    in_ch.left_sample <= l;
    in_ch.right_sample <= rs;
    in_ch.elapsed_time <= et;
    in_ch.sensitivity <= sens;
    in_ch.low_band_energy <= energy;
    if (act == ACT_UPDATE) sb.update_offered = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_item(act, l, rs, et, sens, energy);
  endtask

  // drop valid and wait out every pending period plus the analysis latency
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (sb.periods_due.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SCALE_W-1:0] word);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= word;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.write_reg(idx, word);
  endtask

  task automatic configure(input logic [SCALE_W-1:0] avoid_word,
                           input logic [SCALE_W-1:0] scale_word,
                           input logic [CFG_IDX_W-1:0] spare_idx,
                           input logic [SCALE_W-1:0] spare_word);
    settle();
    set_reg(CFG_AVOID, avoid_word);
    set_reg(CFG_SCALE, scale_word);
    set_reg(spare_idx, spare_word);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic run_phase(input int count, input int calm_from, input int calm_to);
    int k, amp, lv, rv;
    logic signed [SMP_W-1:0] l, rs;
    logic [ET_W-1:0]   et;
    logic [SENS_W-1:0] sens;
    logic [E_W-1:0]    energy;
    amp = 1;
    for (k = 0; k < count; k++) begin
      if (k % 64 == 0) begin
        case ($urandom_range(3))
          0: amp = 1;
          1: amp = 256;
          2: amp = 4096;
          default: amp = 32768;
        endcase
      end
      calm = (k >= calm_from && k < calm_to);
      if ($urandom_range(6) == 0) begin
        case ($urandom_range(9))
          0, 1, 2, 3, 4, 5, 6: et = ET_W'($urandom_range(140, 40));
          7: et = ET_W'($urandom_range(20));
          8: et = 9'd256;
          default: et = ET_W'($urandom_range(511, 257));
        endcase
        case ($urandom_range(9))
          0, 1, 2, 3, 4, 5, 6: energy = E_W'($urandom_range(400));
          7, 8: energy = E_W'($urandom_range(65535, 1000));
          default: energy = E_W'($urandom);
        endcase
        sens = SENS_W'($urandom);
        l = SMP_W'($urandom);
        rs = SMP_W'($urandom);
        send_item(ACT_UPDATE, l, rs, et, sens, energy);
      end else begin
        if ($urandom_range(19) == 0) begin
          l = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
          rs = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
        end else begin
          lv = int'($urandom_range(2 * amp - 1)) - amp;
          rv = int'($urandom_range(2 * amp - 1)) - amp;
          l = lv[SMP_W-1:0];
          rs = rv[SMP_W-1:0];
        end
        et = ET_W'($urandom);
        sens = SENS_W'($urandom);
        energy = E_W'($urandom);
        send_item(ACT_SAMPLE, l, rs, et, sens, energy);
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    calm = 1'b0;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.action <= ACT_SAMPLE;
    in_ch.left_sample <= '0;
    in_ch.right_sample <= '0;
    in_ch.elapsed_time <= '0;
    in_ch.sensitivity <= '0;
    in_ch.low_band_energy <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= CFG_AVOID;
    cfg_ch.data <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    configure(13'd0, 13'd4096, CFG_SPARE0, 13'h1fff);
    // loudest, most negative, and truncation toward zero of odd sums
    send_item(ACT_SAMPLE, 16'sh7fff, 16'sh7fff, 9'h1ff, 7'h7f, 16'hffff);
    send_item(ACT_SAMPLE, 16'sh8000, 16'sh8000, 9'd0, 7'd0, 16'd0);
    send_item(ACT_SAMPLE, 16'sh8000, 16'sh7fff, 9'd3, 7'd5, 16'd9);
    send_item(ACT_SAMPLE, -16'sd1, 16'sd0, 9'd0, 7'd0, 16'd0);
    send_item(ACT_SAMPLE, -16'sd3, 16'sd0, 9'd0, 7'd0, 16'd0);
    send_item(ACT_SAMPLE, 16'sd1, -16'sd2, 9'd0, 7'd0, 16'd0);
    send_item(ACT_SAMPLE, 16'sd0, 16'sd0, 9'd0, 7'd0, 16'd0);
    // no period, then a beat at sensitivity above range, then held energy
    send_item(ACT_UPDATE, 16'sh7fff, 16'sh8000, 9'd0, 7'd0, 16'd0);
    send_item(ACT_UPDATE, 16'sh1234, -16'sd5, 9'd129, 7'h7f, 16'hffff);
    send_item(ACT_UPDATE, 16'sd0, 16'sd0, 9'd128, 7'd0, 16'hffff);
    send_item(ACT_UPDATE, 16'sd0, 16'sd0, 9'h1ff, 7'd100, 16'd0);
    send_item(ACT_UPDATE, 16'sd0, 16'sd0, 9'd256, 7'd50, 16'd40000);
    send_item(ACT_UPDATE, 16'sd0, 16'sd0, 9'd1, 7'd0, 16'd0);
    send_item(ACT_UPDATE, 16'sd0, 16'sd0, 9'd200, 7'd100, 16'hffff);
    send_item(ACT_UPDATE, 16'sd0, 16'sd0, 9'd200, 7'd100, 16'd0);

    configure(13'd0, 13'd0, CFG_SPARE1, 13'd0);
    run_phase(320, 0, 0);
    configure(13'h1fff, 13'h1fff, CFG_SPARE0, 13'($urandom));
    run_phase(320, 0, 0);
    configure(13'h1ffe, 13'h1fff, CFG_SPARE1, 13'h1fff);
    run_phase(320, 60, 260);
    configure(13'd0, 13'($urandom_range(4096)), CFG_SPARE0, 13'($urandom));
    run_phase(320, 0, 0);
    configure(13'd1, 13'd4096, CFG_SPARE1, 13'($urandom));
    run_phase(160, 0, 0);
    configure(13'd0, 13'd4096, CFG_SPARE0, 13'($urandom));
    run_phase(160, 0, 0);

    in_ch.valid <= 1'b0;
    while (sb.periods_due.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
    if (sb.faults == 0 && sb.periods_due.size() == 0 && sb.periods_seen.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
